>>> rtl/core/longest_prefix_route_lookup_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest prefix route lookup block
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_TOP_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define LPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, request codes and the mask length function of the route
// lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

   localparam int AddrBits  = 32;
   localparam int IndexW    = 7;
   localparam int PortW     = 2;
   localparam int LenW      = 6;
   localparam int CsrW      = 8;

   // Request codes carried in req_type
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // One stored route; the prefix is kept already masked
   typedef struct packed {
      logic [AddrBits-1:0] prefix;
      logic [AddrBits-1:0] mask;
      logic [AddrBits-1:0] gateway;
      logic [PortW-1:0]    port;
      logic [LenW-1:0]     len;
   } route_type;

   // Table write command
   typedef struct packed {
      logic              en;
      logic [IndexW-1:0] index;
      route_type         data;
   } wr_cmd_type;

   // Count the set bits of a mask with a balanced adder tree
   function automatic logic [LenW-1:0] mask_len(input logic [AddrBits-1:0] m);
      logic [1:0] l1 [16];
      logic [2:0] l2 [8];
      logic [3:0] l3 [4];
      logic [4:0] l4 [2];
      for (int i = 0; i < 16; i++) begin
         l1[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      end
      return {1'b0, l4[0]} + {1'b0, l4[1]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/lpr_req_if.sv
// ----------------------------------------------------------------------------
// lpr_req_if
// Request channel: table writes and destination lookups.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpr_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [lpr_pkg::IndexW-1:0]    entry_index;
   logic [lpr_pkg::AddrBits-1:0]  new_prefix;
   logic [lpr_pkg::AddrBits-1:0]  new_mask;
   logic [lpr_pkg::AddrBits-1:0]  new_gateway;
   logic [lpr_pkg::PortW-1:0]     new_port;
   logic [lpr_pkg::AddrBits-1:0]  dest_address;

   modport source (
      output valid, req_type, entry_index, new_prefix, new_mask, new_gateway,
             new_port, dest_address,
      input  ready
   );

   modport sink (
      input  valid, req_type, entry_index, new_prefix, new_mask, new_gateway,
             new_port, dest_address,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/lpr_rsp_if.sv
// ----------------------------------------------------------------------------
// lpr_rsp_if
// Response channel: one beat per lookup.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [lpr_pkg::AddrBits-1:0]  gateway;
   logic [lpr_pkg::PortW-1:0]     out_port;
   logic [lpr_pkg::LenW-1:0]      prefix_length;

   modport source (
      output valid, found, gateway, out_port, prefix_length,
      input  ready
   );

   modport sink (
      input  valid, found, gateway, out_port, prefix_length,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/longest_prefix_route_lookup_top.sv
// Longest prefix route lookup.
// req_bus carries one beat per request: req_type selects a table write
// (entry_index, new_prefix, new_mask, new_gateway, new_port) or a lookup
// (dest_address). A write gives no response.
// A lookup reads entries 0 .. N-1 from the route memory, N being
// entries_in_use saturated to ROUTES, one per cycle through its single read
// port, and gives one rsp_bus beat: found, gateway, out_port, prefix_length
// (all zero when nothing matched). The LAST state compares the last read
// data and the FINISH state loads the response register; the next request
// is taken as that response beat becomes valid. The scan of the route memory
// sets how long a lookup holds the block.
// csr_we/csr_wdata write entries_in_use; write it only while idle.
// Reset clears the count register, the state and valid flags; table contents
// are undefined until written. When rsp_bus stalls, the response register
// holds its beat; the next request is taken meanwhile, and a lookup that
// finishes waits for the register to free up before going idle again.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_top
// Top level: count register, route memory and scan control.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup_top #(
   parameter int ROUTES = 128
) (
   input  wire                      clock,
   input  wire                      reset,
   lpr_req_if.sink                  req_bus,
   lpr_rsp_if.source                rsp_bus,
   input  wire                      csr_we,
   input  wire [lpr_pkg::CsrW-1:0]  csr_wdata
);

   localparam int AddrW = $clog2(ROUTES);

   logic [lpr_pkg::CsrW-1:0] csr_entries_ff, csr_entries_in;
   lpr_pkg::wr_cmd_type      wr_cmd;
   logic                     rd_en;
   logic [AddrW-1:0]         rd_addr;
   lpr_pkg::route_type       rd_data;

   // Update the entry count on a write
   assign csr_entries_in = csr_we ? csr_wdata : csr_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_entries_ff <= '0;
      end else begin
         csr_entries_ff <= csr_entries_in;
      end
   end

   lpr_table #(
      .ROUTES (ROUTES)
   ) u_table (
      .clock   (clock),
      .wr_cmd  (wr_cmd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lpr_scan #(
      .ROUTES (ROUTES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_entries (csr_entries_ff),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .wr_cmd      (wr_cmd),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/lpr_table.sv
// ----------------------------------------------------------------------------
// lpr_table
// Route memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_table #(
   parameter int ROUTES = 128
) (
   input  wire                       clock,
   input  lpr_pkg::wr_cmd_type       wr_cmd,
   input  wire                       rd_en,
   input  wire [$clog2(ROUTES)-1:0]  rd_addr,
   output lpr_pkg::route_type        rd_data
);

   localparam int AddrW = $clog2(ROUTES);

   lpr_pkg::route_type route_mem [ROUTES];
   lpr_pkg::route_type rd_data_ff;

   // Store an entry; drop writes beyond the table
   always_ff @(posedge clock) begin
      if (wr_cmd.en && (32'(wr_cmd.index) < ROUTES)) begin
         route_mem[AddrW'(wr_cmd.index)] <= wr_cmd.data;
      end
   end

   // Read one entry per cycle while rd_en is high
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= route_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpr_scan.sv
// ----------------------------------------------------------------------------
// lpr_scan
// Request decode, scan sequencer, best-match tracking and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_scan #(
   parameter int ROUTES = 128
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [lpr_pkg::CsrW-1:0]     csr_entries,
   lpr_req_if.sink                     req_bus,
   lpr_rsp_if.source                   rsp_bus,
   output lpr_pkg::wr_cmd_type         wr_cmd,
   output logic                        rd_en,
   output logic [$clog2(ROUTES)-1:0]   rd_addr,
   input  lpr_pkg::route_type          rd_data
);

   localparam int AddrW = $clog2(ROUTES);
   localparam int CntW  = $clog2(ROUTES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [lpr_pkg::AddrBits-1:0]    dest_ff, dest_in;
   logic [CntW-1:0]                 count_ff, count_in;
   logic [AddrW-1:0]                addr_ff, addr_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic                            hit_ff, hit_in;
   logic [lpr_pkg::LenW-1:0]        best_len_ff, best_len_in;
   logic [lpr_pkg::AddrBits-1:0]    best_hop_ff, best_hop_in;
   logic [lpr_pkg::PortW-1:0]       best_port_ff, best_port_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff;
   logic [lpr_pkg::AddrBits-1:0]    rsp_hop_ff;
   logic [lpr_pkg::PortW-1:0]       rsp_port_ff;
   logic [lpr_pkg::LenW-1:0]        rsp_len_ff;

   logic                            accept;
   logic                            last_issue;
   logic                            match;
   logic                            load;
   logic [CntW-1:0]                 sat_count;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // Build the table write for a write beat
   always_comb begin
      wr_cmd.en            = accept && (req_bus.req_type == lpr_pkg::REQ_WRITE);
      wr_cmd.index         = req_bus.entry_index;
      wr_cmd.data.prefix   = req_bus.new_prefix & req_bus.new_mask;
      wr_cmd.data.mask     = req_bus.new_mask;
      wr_cmd.data.gateway  = req_bus.new_gateway;
      wr_cmd.data.port     = req_bus.new_port;
      wr_cmd.data.len      = lpr_pkg::mask_len(req_bus.new_mask);
   end

   // Clamp the entry count to the table depth
   assign sat_count = (32'(csr_entries) > 32'(ROUTES)) ? CntW'(ROUTES)
                                                        : CntW'(csr_entries);

   assign rd_en      = (state_ff == ST_SCAN);
   assign rd_addr    = addr_ff;
   assign last_issue = ((CntW'(addr_ff) + CntW'(1)) == count_ff);

   // Compare the entry read last cycle; strictly longer wins
   assign match = rd_valid_ff
                  && (rd_data.prefix == (dest_ff & rd_data.mask))
                  && (rd_data.len > best_len_ff);

   // Sequence the scan
   always_comb begin
      state_in     = state_ff;
      dest_in      = dest_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_valid_in  = 1'b0;
      hit_in       = hit_ff;
      best_len_in  = best_len_ff;
      best_hop_in  = best_hop_ff;
      best_port_in = best_port_ff;
      load         = 1'b0;

      if (match) begin
         hit_in       = 1'b1;
         best_len_in  = rd_data.len;
         best_hop_in  = rd_data.gateway;
         best_port_in = rd_data.port;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_bus.req_type == lpr_pkg::REQ_LOOKUP)) begin
               dest_in      = req_bus.dest_address;
               count_in     = sat_count;
               addr_in      = '0;
               hit_in       = 1'b0;
               best_len_in  = '0;
               best_hop_in  = '0;
               best_port_in = '0;
               state_in     = (sat_count == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            addr_in     = addr_ff + AddrW'(1);
            if (last_issue) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Hold the response until the sink takes it
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dest_ff      <= dest_in;
      count_ff     <= count_in;
      addr_ff      <= addr_in;
      hit_ff       <= hit_in;
      best_len_ff  <= best_len_in;
      best_hop_ff  <= best_hop_in;
      best_port_ff <= best_port_in;
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_found_ff <= hit_ff;
         rsp_hop_ff   <= best_hop_ff;
         rsp_port_ff  <= best_port_ff;
         rsp_len_ff   <= best_len_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.found         = rsp_found_ff;
   assign rsp_bus.gateway       = rsp_hop_ff;
   assign rsp_bus.out_port      = rsp_port_ff;
   assign rsp_bus.prefix_length = rsp_len_ff;

endmodule

`default_nettype wire

>>> rtl/core/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks of the route lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_prefix_route_lookup_top_defines.svh"

module lpr_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire                           found,
   input wire [lpr_pkg::AddrBits-1:0]   gateway,
   input wire [lpr_pkg::PortW-1:0]      out_port,
   input wire [lpr_pkg::LenW-1:0]       prefix_length
);

   logic                                                    req_beat;
   logic                                                    rsp_stall;
   logic                                                    route_zero;
   logic                                                    len_ok;
   logic [lpr_pkg::AddrBits+lpr_pkg::PortW+lpr_pkg::LenW:0] rsp_beat;

   assign req_beat   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign route_zero = (gateway == '0) && (out_port == '0) && (prefix_length == '0);
   assign len_ok     = (prefix_length != '0) && (prefix_length <= lpr_pkg::LenW'(32));
   assign rsp_beat   = {found, gateway, out_port, prefix_length};

   // No response beat survives reset
   `LPR_ASSERT_ALWAYS(a_rst_no_rsp, clock, reset |=> !rsp_valid, "response valid after reset")

   // Hold a stalled response beat
   `LPR_ASSERT(a_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_beat), "beat moved")

   // A miss carries all-zero route fields
   `LPR_ASSERT(a_miss_zero, clock, reset, rsp_valid && !found |-> route_zero, "miss with fields")

   // A hit has a nonempty mask of at most 32 bits
   `LPR_ASSERT(a_hit_len, clock, reset, rsp_valid && found |-> len_ok, "hit with bad length")

   // A response never appears the cycle after a request beat
   `LPR_ASSERT(a_no_fast_rsp, clock, reset, req_beat |=> !$rose(rsp_valid), "response too soon")

endmodule

bind longest_prefix_route_lookup_top lpr_checker u_lpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .found         (rsp_bus.found),
   .gateway       (rsp_bus.gateway),
   .out_port      (rsp_bus.out_port),
   .prefix_length (rsp_bus.prefix_length)
);

`default_nettype wire
